/* sv/frustum_cull_test_unit_assert.svh */
// Assertion macros for the frustum cull test unit
`ifndef FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define FCT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define FCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg
// Shared constants and types for the frustum cull test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fct_pkg;
    localparam int NUM_PLANES = 6;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 3;
    localparam int ACC_W      = 72;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_POINT  = 3'd1;
    localparam logic [2:0] OP_SPHERE = 3'd2;
    localparam logic [2:0] OP_CUBE   = 3'd3;
    localparam logic [2:0] OP_BOX    = 3'd4;

    typedef logic signed [31:0] word_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } plane_t;
endpackage

/* sv/frustum_cull_test_unit.sv */
// ----------------------------------------------------------------------------
// frustum_cull_test_unit
// Tests points, spheres, cubes and boxes against six stored planes.
// ----------------------------------------------------------------------------
// Pipeline: four register stages from input transfer to result valid.
// Throughput: one item per cycle unless the output stalls; six plane dot products run in parallel lanes.
// Stages: multiply, partial sums, final sum and sign, all-planes AND.
// Reset: clears stage valid bits only; plane registers are undefined until loaded.
// Stall: the whole pipe holds while the output waits and a result is present.
`timescale 1ns / 1ps
module frustum_cull_test_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [2:0]  s_plane_index,
    input  logic signed [31:0] s_plane_a,
    input  logic signed [31:0] s_plane_b,
    input  logic signed [31:0] s_plane_c,
    input  logic signed [31:0] s_plane_d,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic [30:0] s_extent_x,
    input  logic [30:0] s_extent_y,
    input  logic [30:0] s_extent_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_inside_res
);
    import fct_pkg::*;

    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Plane storage, written by load transfers
    plane_t planes_reg [NUM_PLANES];
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_operation == OP_LOAD &&
            s_plane_index < IDX_W'(NUM_PLANES)) begin
            planes_reg[s_plane_index[IDX_W-1:0]] <= {s_plane_a, s_plane_b,
                                                     s_plane_c, s_plane_d};
        end
    end

    // Stage 0 decode
    logic query;
    logic signed [31:0] ex_s, ey_s, ez_s;
    logic signed [ACC_W-1:0] bias_s;
    always_comb begin
        query = s_valid && (s_operation == OP_POINT || s_operation == OP_SPHERE ||
                            s_operation == OP_CUBE || s_operation == OP_BOX);
        ex_s = 32'sd0; ey_s = 32'sd0; ez_s = 32'sd0; bias_s = '0;
        case (s_operation)
            OP_SPHERE: bias_s = acc_t'({1'b0, s_extent_x}) <<< FRAC_BITS;
            OP_CUBE: begin
                ex_s = {1'b0, s_extent_x}; ey_s = ex_s; ez_s = ex_s;
            end
            OP_BOX: begin
                ex_s = {1'b0, s_extent_x};
                ey_s = {1'b0, s_extent_y};
                ez_s = {1'b0, s_extent_z};
            end
            default: ;
        endcase
    end

    // Stage 1: products
    logic v1_reg, v2_reg, v3_reg;
    logic signed [63:0] px_reg[NUM_PLANES], py_reg[NUM_PLANES], pz_reg[NUM_PLANES];
    logic signed [63:0] qx_reg[NUM_PLANES], qy_reg[NUM_PLANES], qz_reg[NUM_PLANES];
    acc_t d1_reg[NUM_PLANES];
    acc_t bias1_reg;
    acc_t s2a_reg[NUM_PLANES], s2b_reg[NUM_PLANES];
    logic [NUM_PLANES-1:0] pass3_reg;
    logic m_inside_reg, m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= query && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bias1_reg <= bias_s;
            for (int p = 0; p < NUM_PLANES; p++) begin
                px_reg[p] <= planes_reg[p].a * s_pos_x;
                py_reg[p] <= planes_reg[p].b * s_pos_y;
                pz_reg[p] <= planes_reg[p].c * s_pos_z;
                qx_reg[p] <= (planes_reg[p].a < 0) ? -(planes_reg[p].a * ex_s)
                                                    : planes_reg[p].a * ex_s;
                qy_reg[p] <= (planes_reg[p].b < 0) ? -(planes_reg[p].b * ey_s)
                                                    : planes_reg[p].b * ey_s;
                qz_reg[p] <= (planes_reg[p].c < 0) ? -(planes_reg[p].c * ez_s)
                                                    : planes_reg[p].c * ez_s;
                d1_reg[p] <= acc_t'(planes_reg[p].d) <<< FRAC_BITS;
            end
            // Stage 2: partial sums
            for (int p = 0; p < NUM_PLANES; p++) begin
                s2a_reg[p] <= acc_t'(px_reg[p]) + acc_t'(py_reg[p]) +
                              acc_t'(pz_reg[p]) + d1_reg[p];
                s2b_reg[p] <= acc_t'(qx_reg[p]) + acc_t'(qy_reg[p]) +
                              acc_t'(qz_reg[p]) + bias1_reg;
            end
            // Stage 3: final sum and sign
            for (int p = 0; p < NUM_PLANES; p++) begin
                pass3_reg[p] <= (s2a_reg[p] + s2b_reg[p]) >= 0;
            end
            // Stage 4: combine
            m_inside_reg <= &pass3_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_inside_res = m_inside_reg;
endmodule

/* sv/fct_checker.sv */
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks for the frustum cull test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_cull_test_unit_assert.svh"
module fct_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_inside_res
);
    // A stalled result holds its value
    `FCT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_inside_res))
    // Input is ready whenever the output is free
    `FCT_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid || m_ready, s_ready)
    // No input transfer while a result is stalled
    `FCT_ASSERT_IMP(a_stall, aclk, aresetn, s_valid && m_valid && !m_ready, !s_ready)
    // Nothing appears with an empty pipe after reset
    `FCT_ASSERT_NEXT(a_rst, aclk, 1'b1, !aresetn, !m_valid)
endmodule

bind frustum_cull_test_unit fct_checker u_fct_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_inside_res(m_inside_res)
);
